### rtl/core/gcms_pkg.sv
package gcms_pkg;

  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned SIZE_W   = 9;

  // one pending-result flag per kind, emitted lowest index first
  localparam int unsigned RES_ABOVE  = 0;  // sample of the row above the incoming one
  localparam int unsigned RES_BESIDE = 1;  // last row, one column behind the input
  localparam int unsigned RES_CORNER = 2;  // bottom right sample of the grid
  localparam int unsigned RES_KINDS  = 3;

  typedef logic signed [HEIGHT_W-1:0] height_t;
  typedef logic [COORD_W-1:0]         coord_t;
  typedef logic [SIZE_W-1:0]          size_t;
  typedef logic [RES_KINDS-1:0]       pend_t;

  typedef struct packed {
    height_t height;
    coord_t  column;
    coord_t  row;
    logic    last;
  } result_t;

  // floor of the four-sample sum over four
  function automatic height_t mean4(height_t a, height_t b, height_t c, height_t d);
    logic [HEIGHT_W+1:0] sum;
    sum = {{2{a[HEIGHT_W-1]}}, a} + {{2{b[HEIGHT_W-1]}}, b}
        + {{2{c[HEIGHT_W-1]}}, c} + {{2{d[HEIGHT_W-1]}}, d};
    return sum[HEIGHT_W+1:2];
  endfunction

endpackage

### rtl/core/gcms_in_if.sv
interface gcms_in_if import gcms_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t height_in;

  modport source(output valid, output height_in, input ready);
  modport sink(input valid, input height_in, output ready);
endinterface

### rtl/core/gcms_out_if.sv
interface gcms_out_if import gcms_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t height_out;
  coord_t  out_column;
  coord_t  out_row;
  logic    last_of_frame;

  modport source(output valid, output height_out, output out_column, output out_row,
                 output last_of_frame, input ready);
  modport sink(input valid, input height_out, input out_column, input out_row,
               input last_of_frame, output ready);
endinterface

### rtl/core/gcms_ram.sv
module gcms_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/grid_cross_mean_smoother_core.sv
// Four-neighbor mean smoother for a square grid of signed Q8.8 heights streamed in
// raster order; each result is floor((up + down + left + right) / 4) of the original
// samples with coordinates clamped at the grid edge, tagged with its row, column and
// an end-of-frame flag on the bottom right sample. Row r is emitted while row r+1
// streams in, so a frame's first row produces nothing and its last row produces one
// result for its first input, two for each later one and three for the final sample.
// Inputs are taken one per cycle while the output buffer has space; the single result
// port sets the pace in the last row, where an input is taken only once at most one
// result of the one before is still pending.
// Two line stores of min(MAX_SIZE, 256) x 16 bits are read one column
// ahead and written at the column of each transfer; they need no clearing after reset.
// Writing cfg_wdata_i sets the grid size (clamped to 2 .. min(MAX_SIZE, 256)) and
// restarts the frame; write it only while no results are outstanding.
module grid_cross_mean_smoother_core import gcms_pkg::*; #(
  parameter int unsigned MAX_SIZE = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  gcms_in_if.sink           in_i,
  gcms_out_if.source        out_o
);

  localparam int unsigned DEPTH = (MAX_SIZE < 256) ? MAX_SIZE : 256;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam size_t       LIMIT = SIZE_W'(DEPTH);
  localparam size_t       SMALLEST = SIZE_W'(2);

  // grid size and position counters
  size_t  size_q, size_d;
  coord_t col_q, col_d;
  coord_t row_q, row_d;
  size_t  last_idx;
  logic   col_is_last;
  logic   row_is_last;
  coord_t col_next;
  logic   in_xfer;

  // line stores
  height_t prev_rd;
  height_t older_rd;

  // emitter stage
  pend_t   pend_q, pend_d;
  height_t x_q;
  height_t pc_q;
  height_t ppc_q;
  height_t cen_q;
  height_t up_q;
  height_t left_q;
  coord_t  c1_q;
  coord_t  r1_q;
  height_t op_a, op_b, op_c, op_d;
  height_t right_val;
  result_t push_res;
  logic    emit_valid;
  logic    push;

  // output buffer
  result_t  fifo_q [2];
  logic     wr_ptr_q;
  logic     rd_ptr_q;
  logic [1:0] count_q;
  logic     space;
  logic     pop;

  assign last_idx    = size_q - SIZE_W'(1);
  assign col_is_last = ({1'b0, col_q} == last_idx);
  assign row_is_last = ({1'b0, row_q} == last_idx);
  assign col_next    = col_is_last ? '0 : col_q + COORD_W'(1);

  assign space      = (count_q != 2'd2);
  assign emit_valid = (pend_q != '0);
  assign push       = emit_valid && space;
  assign in_i.ready = (pend_q == '0) || (space && $onehot(pend_q));
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    size_d = size_q;
    col_d  = col_q;
    row_d  = row_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i < SMALLEST) begin
        size_d = SMALLEST;
      end else if (cfg_wdata_i > LIMIT) begin
        size_d = LIMIT;
      end else begin
        size_d = cfg_wdata_i;
      end
      col_d = '0;
      row_d = '0;
    end else if (in_xfer) begin
      col_d = col_next;
      if (col_is_last) begin
        row_d = row_is_last ? '0 : row_q + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= LIMIT;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      size_q <= size_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  // older row takes the previous-row value that the new sample replaces
  gcms_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(DEPTH)
  ) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (in_xfer),
    .waddr_i(col_q[AW-1:0]),
    .wdata_i(in_i.height_in),
    .re_i   (in_xfer),
    .raddr_i(col_next[AW-1:0]),
    .rdata_o(prev_rd)
  );

  gcms_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(DEPTH)
  ) u_older_ram (
    .clk_i  (clk_i),
    .we_i   (in_xfer),
    .waddr_i(col_q[AW-1:0]),
    .wdata_i(prev_rd),
    .re_i   (in_xfer),
    .raddr_i(col_next[AW-1:0]),
    .rdata_o(older_rd)
  );

  // pending results: clear the lowest flag per pushed result, reload on a transfer
  always_comb begin
    pend_d = pend_q;
    if (push) begin
      pend_d = pend_q & (pend_q - pend_t'(1));
    end
    if (in_xfer) begin
      pend_d[RES_ABOVE]  = (row_q != '0);
      pend_d[RES_BESIDE] = row_is_last && (col_q != '0);
      pend_d[RES_CORNER] = row_is_last && col_is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // window of the neighborhood, shifted one column per transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q    <= in_i.height_in;
      pc_q   <= x_q;
      ppc_q  <= pc_q;
      cen_q  <= prev_rd;
      up_q   <= older_rd;
      left_q <= (col_q != '0) ? cen_q : prev_rd;
      c1_q   <= col_q;
      r1_q   <= row_q;
    end
  end

  // prev_rd now holds the next column of the row above
  assign right_val = (({1'b0, c1_q} + SIZE_W'(1)) < size_q) ? prev_rd : cen_q;

  always_comb begin
    op_a = x_q;
    op_b = cen_q;
    op_c = pc_q;
    op_d = x_q;
    push_res.column = c1_q;
    push_res.row    = r1_q;
    push_res.last   = 1'b1;
    priority if (pend_q[RES_ABOVE]) begin
      op_a = x_q;
      op_b = (r1_q == COORD_W'(1)) ? cen_q : up_q;
      op_c = left_q;
      op_d = right_val;
      push_res.row  = r1_q - COORD_W'(1);
      push_res.last = 1'b0;
    end else if (pend_q[RES_BESIDE]) begin
      op_a = pc_q;
      op_b = left_q;
      op_c = (c1_q >= COORD_W'(2)) ? ppc_q : pc_q;
      op_d = x_q;
      push_res.column = c1_q - COORD_W'(1);
      push_res.last   = 1'b0;
    end else begin
      op_a = x_q;
      op_b = cen_q;
      op_c = pc_q;
      op_d = x_q;
    end
    push_res.height = mean4(op_a, op_b, op_c, op_d);
  end

  // two-entry output buffer
  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_o.valid         = (count_q != '0);
  assign out_o.height_out    = fifo_q[rd_ptr_q].height;
  assign out_o.out_column    = fifo_q[rd_ptr_q].column;
  assign out_o.out_row       = fifo_q[rd_ptr_q].row;
  assign out_o.last_of_frame = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer count out of range");

  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < size_q) && ({1'b0, row_q} < size_q))
    else $error("position counters beyond grid size");

  a_first_row_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (row_q == '0)) |=> (pend_q == '0))
    else $error("first row transfer left results pending");

  a_corner_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_of_frame) |-> (out_o.out_row == out_o.out_column))
    else $error("end of frame flag off the corner");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q >= SMALLEST) && (size_q <= LIMIT))
    else $error("grid size outside supported range");
`endif

endmodule
